FILE: hw/rtl/fdrc_pkg.sv
`default_nettype none
package fdrc_pkg;
  localparam int unsigned MaxWidth   = 1024;
  localparam int unsigned MaxHeight  = 1024;
  localparam int unsigned MaxBoxes   = 64;
  localparam int unsigned XW         = $clog2(MaxWidth);
  localparam int unsigned YW         = $clog2(MaxHeight);
  localparam int unsigned AW         = XW + YW;
  localparam int unsigned BIW        = $clog2(MaxBoxes);
  localparam int unsigned BCW        = $clog2(MaxBoxes + 1);
  localparam int unsigned BoxW       = 2 * XW + 2 * YW;
  localparam logic [20:0] CountMax   = 21'h1FFFFF;
  localparam logic [15:0] DropMax    = 16'hFFFF;
  localparam logic [14:0] NoLow      = 15'h7FFF;

  localparam logic [2:0] RegWidth  = 3'd0;
  localparam logic [2:0] RegHeight = 3'd1;
  localparam logic [2:0] RegKey    = 3'd2;
  localparam logic [2:0] RegVpEn   = 3'd3;
  localparam logic [2:0] RegVpL    = 3'd4;
  localparam logic [2:0] RegVpT    = 3'd5;
  localparam logic [2:0] RegVpR    = 3'd6;
  localparam logic [2:0] RegVpB    = 3'd7;

  localparam logic [1:0] CodeSame  = 2'd0;
  localparam logic [1:0] CodeExpl  = 2'd1;
  localparam logic [1:0] CodeUnexp = 2'd2;

  typedef struct packed {
    logic in_fire;
    logic scan_start;
    logic scan_step;
    logic finish;
    logic out_take;
  } fdrc_cmd_t;

  typedef struct packed {
    logic is_pixel;
    logic scan_last;
    logic out_full;
  } fdrc_sts_t;
endpackage
`default_nettype wire

FILE: hw/rtl/fdrc_ram.sv
`default_nettype none
module fdrc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire [$clog2(Depth)-1:0]  waddr_i,
  input  wire [Width-1:0]          wdata_i,
  input  wire [$clog2(Depth)-1:0]  raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

FILE: hw/rtl/fdrc_ctrl.sv
`default_nettype none
module fdrc_ctrl
  import fdrc_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  wire        out_ready_i,
  output logic       out_valid_o,
  input  fdrc_sts_t  sts_i,
  output fdrc_cmd_t  cmd_o
);
  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StLoad = 4'b0010,
    StScan = 4'b0100,
    StDone = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.in_fire = 1'b1;
          if (sts_i.is_pixel) state_d = StLoad;
        end
      end
      StLoad: begin
        cmd_o.scan_start = 1'b1;
        state_d = StScan;
      end
      StScan: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) state_d = StDone;
      end
      StDone: begin
        if (!sts_i.out_full || out_ready_i) begin
          cmd_o.finish = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
    cmd_o.out_take = sts_i.out_full && out_ready_i;
  end

  assign out_valid_o = sts_i.out_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end
endmodule
`default_nettype wire

FILE: hw/rtl/fdrc_dp.sv
`default_nettype none
module fdrc_dp
  import fdrc_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          cfg_we_i,
  input  wire  [2:0]   cfg_idx_i,
  input  wire  [10:0]  cfg_data_i,
  input  wire  [91:0]  in_data_i,
  input  wire          in_last_i,
  input  wire          in_user_i,
  output logic [119:0] out_data_o,
  input  fdrc_cmd_t    cmd_i,
  output fdrc_sts_t    sts_o
);
  logic [10:0] width_q, height_q;
  logic [7:0]  key_q;
  logic        vpen_q;
  logic [9:0]  vpl_q, vpt_q, vpr_q, vpb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 11'd640; height_q <= 11'd480; key_q <= 8'd254; vpen_q <= 1'b0;
      vpl_q <= '0; vpt_q <= '0; vpr_q <= '0; vpb_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegWidth:  width_q <= cfg_data_i;
        RegHeight: height_q <= cfg_data_i;
        RegKey:    key_q <= cfg_data_i[7:0];
        RegVpEn:   vpen_q <= cfg_data_i[0];
        RegVpL:    vpl_q <= cfg_data_i[9:0];
        RegVpT:    vpt_q <= cfg_data_i[9:0];
        RegVpR:    vpr_q <= cfg_data_i[9:0];
        RegVpB:    vpb_q <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  logic [11:0] eff_w, eff_h;
  assign eff_w = (width_q > 11'(MaxWidth)) ? 12'(MaxWidth) : {1'b0, width_q};
  assign eff_h = (height_q > 11'(MaxHeight)) ? 12'(MaxHeight) : {1'b0, height_q};

  logic [XW-1:0] col_q;
  logic [YW-1:0] row_q;
  logic [7:0]    val_q;
  logic          last_q, inside_q;

  logic [XW-1:0] col_in;
  logic [YW-1:0] row_in;
  assign col_in = in_data_i[XW-1:0];
  assign row_in = in_data_i[XW+YW-1:XW];

  logic signed [15:0] bl_q, bt_q, br_q, bb_q;
  logic signed [16:0] wm1, hm1, cl, ct, cr, cb;
  assign wm1 = signed'({5'd0, eff_w}) - 17'sd1;
  assign hm1 = signed'({5'd0, eff_h}) - 17'sd1;
  assign cl = (bl_q < 0) ? 17'sd0 : 17'(bl_q);
  assign ct = (bt_q < 0) ? 17'sd0 : 17'(bt_q);
  assign cr = (17'(br_q) > wm1) ? wm1 : 17'(br_q);
  assign cb = (17'(bb_q) > hm1) ? hm1 : 17'(bb_q);

  logic [BCW-1:0] box_cnt_q;
  logic [15:0]    drop_q;
  logic           box_pend_q;
  logic           bwe;
  logic [BoxW-1:0] bwdata, brdata;
  logic [BIW-1:0]  braddr_q;
  logic            box_empty;
  assign box_empty = (cl > cr) || (ct > cb);
  assign bwe = box_pend_q && !box_empty && (box_cnt_q < BCW'(MaxBoxes));
  assign bwdata = {cb[YW-1:0], cr[XW-1:0], ct[YW-1:0], cl[XW-1:0]};

  fdrc_ram #(.Width(BoxW), .Depth(MaxBoxes)) u_boxes (
    .clk_i, .we_i(bwe), .waddr_i(box_cnt_q[BIW-1:0]), .wdata_i(bwdata),
    .raddr_i(braddr_q), .rdata_o(brdata)
  );

  logic [7:0] prev_rd;
  logic       pwe;
  logic       prev_valid_q;
  assign pwe = cmd_i.scan_start && inside_q;
  fdrc_ram #(.Width(8), .Depth(MaxWidth * MaxHeight)) u_prev (
    .clk_i, .we_i(pwe), .waddr_i({row_q, col_q}), .wdata_i(val_q),
    .raddr_i({row_in, col_in}), .rdata_o(prev_rd)
  );

  logic [7:0] prev_q;
  logic       hit_q;
  logic [BCW-1:0] scan_n_q;
  logic           scan_act_q;
  logic [XW-1:0] el, er;
  logic [YW-1:0] et, eb;
  assign el = brdata[XW-1:0];
  assign et = brdata[XW+YW-1:XW];
  assign er = brdata[2*XW+YW-1:XW+YW];
  assign eb = brdata[BoxW-1:2*XW+YW];

  assign sts_o.is_pixel = in_user_i;
  assign sts_o.scan_last = !scan_act_q || (scan_n_q >= box_cnt_q);

  logic [20:0] chg_q, unx_q;
  logic [14:0] rl_q, rt_q;
  logic signed [10:0] rr_q, rb_q;
  logic        out_full_q;
  logic [119:0] obuf_q;
  assign sts_o.out_full = out_full_q;
  assign out_data_o = obuf_q;

  logic changed, vp_hit, expl;
  assign changed = prev_valid_q && inside_q && (prev_q != val_q);
  assign vp_hit = vpen_q && (val_q == key_q) && (col_q >= vpl_q) && (col_q <= vpr_q)
                  && (row_q >= vpt_q) && (row_q <= vpb_q);
  assign expl = hit_q || vp_hit;

  logic [1:0] code;
  logic [20:0] chg_n, unx_n;
  logic [14:0] rl_n, rt_n;
  logic signed [10:0] rr_n, rb_n;
  always_comb begin
    code = CodeSame;
    chg_n = chg_q; unx_n = unx_q; rl_n = rl_q; rt_n = rt_q; rr_n = rr_q; rb_n = rb_q;
    if (changed) begin
      if (chg_q != CountMax) chg_n = chg_q + 21'd1;
      if (expl) code = CodeExpl;
      else begin
        code = CodeUnexp;
        if (unx_q != CountMax) unx_n = unx_q + 21'd1;
        if (15'(col_q) < rl_q) rl_n = 15'(col_q);
        if (15'(row_q) < rt_q) rt_n = 15'(row_q);
        if (signed'({1'b0, col_q}) > rr_q) rr_n = signed'({1'b0, col_q});
        if (signed'({1'b0, row_q}) > rb_q) rb_n = signed'({1'b0, row_q});
      end
    end
  end

  logic [119:0] obuf_d;
  always_comb begin
    obuf_d = '0;
    obuf_d[1:0] = code;
    if (last_q) begin
      obuf_d[2] = 1'b1;
      obuf_d[23:3] = chg_n;
      obuf_d[44:24] = unx_n;
      obuf_d[59:45] = rl_n;
      obuf_d[74:60] = rt_n;
      obuf_d[85:75] = rr_n;
      obuf_d[96:86] = rb_n;
      obuf_d[112:97] = drop_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_fire) begin
      col_q <= col_in; row_q <= row_in; val_q <= in_data_i[27:20];
      last_q <= in_last_i;
      inside_q <= ({2'b0, col_in} < eff_w) && ({2'b0, row_in} < eff_h);
      bl_q <= in_data_i[43:28]; bt_q <= in_data_i[59:44];
      br_q <= in_data_i[75:60]; bb_q <= in_data_i[91:76];
    end
    if (cmd_i.scan_start) prev_q <= prev_rd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_cnt_q <= '0; drop_q <= '0; box_pend_q <= 1'b0; prev_valid_q <= 1'b0;
      braddr_q <= '0; scan_n_q <= '0; scan_act_q <= 1'b0; hit_q <= 1'b0;
      chg_q <= '0; unx_q <= '0; rl_q <= NoLow; rt_q <= NoLow; rr_q <= -11'sd1;
      rb_q <= -11'sd1; out_full_q <= 1'b0; obuf_q <= '0;
    end else begin
      box_pend_q <= cmd_i.in_fire && !in_user_i;
      if (cmd_i.finish && last_q) begin
        box_cnt_q <= '0; drop_q <= '0;
      end else if (bwe) begin
        box_cnt_q <= box_cnt_q + BCW'(1);
      end else if (box_pend_q && !box_empty && drop_q != DropMax) begin
        drop_q <= drop_q + 16'd1;
      end
      if (cmd_i.in_fire) begin
        braddr_q <= '0;
      end else if (cmd_i.scan_start) begin
        hit_q <= 1'b0; scan_n_q <= '0; scan_act_q <= (box_cnt_q != '0);
        braddr_q <= (box_cnt_q > BCW'(1)) ? BIW'(1) : '0;
      end else if (cmd_i.scan_step && scan_act_q && scan_n_q < box_cnt_q) begin
        if (col_q >= el && col_q <= er && row_q >= et && row_q <= eb) hit_q <= 1'b1;
        scan_n_q <= scan_n_q + BCW'(1);
        if (scan_n_q + BCW'(2) < box_cnt_q) braddr_q <= braddr_q + BIW'(1);
      end
      if (cmd_i.finish) out_full_q <= 1'b1;
      else if (cmd_i.out_take) out_full_q <= 1'b0;
      if (cmd_i.finish) begin
        obuf_q <= obuf_d;
        if (last_q) begin
          prev_valid_q <= 1'b1;
          chg_q <= '0; unx_q <= '0;
          rl_q <= NoLow; rt_q <= NoLow; rr_q <= -11'sd1; rb_q <= -11'sd1;
        end else begin
          chg_q <= chg_n; unx_q <= unx_n; rl_q <= rl_n; rt_q <= rt_n;
          rr_q <= rr_n; rb_q <= rb_n;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/frame_diff_region_census.sv
// Change census of a watched surface, one beat at a time.
// The slave side takes box beats (tuser 0) and pixel beats (tuser 1);
// tlast marks the final pixel of a frame. Box beats give no result.
// Each pixel beat gives one master beat with its mask code and, when
// it closed the frame, the frame totals.
// After a pixel beat is accepted, the frame copy is read and the box
// table is scanned, one entry per cycle, before the result is registered.
// The next beat can be accepted once that result is registered.
// A box beat is stored in the following cycle, and the next beat can be
// accepted right away.
// A result waits in an output register while the receiver stalls; a
// following pixel beat is accepted but holds until that register is free.
// Reset restores default geometry, empties the box table and marks the
// frame copy as not yet filled; the first frame only fills the copy.
// Configuration registers should be written only while no beat is in flight.
`default_nettype none
module frame_diff_region_census
  import fdrc_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          cfg_we_i,
  input  wire  [2:0]   cfg_idx_i,
  input  wire  [10:0]  cfg_data_i,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // column, row, pixel_value, box_left, box_top, box_right, box_bottom
  input  wire  [95:0]  s_axis_tdata,
  input  wire          s_axis_tlast,
  // mode
  input  wire          s_axis_tuser,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // mask_code, frame_done, changed_count, unexplained_count, region_left,
  // region_top, region_right, region_bottom, boxes_dropped
  output logic [119:0] m_axis_tdata
);
  fdrc_cmd_t cmd;
  fdrc_sts_t sts;

  fdrc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_ready_i(m_axis_tready), .out_valid_o(m_axis_tvalid), .sts_i(sts), .cmd_o(cmd)
  );

  fdrc_dp u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_data_i(s_axis_tdata[91:0]), .in_last_i(s_axis_tlast), .in_user_i(s_axis_tuser),
    .out_data_o(m_axis_tdata), .cmd_i(cmd), .sts_o(sts)
  );
endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`default_nettype none
module tb_top;
  import fdrc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [3:0]         pad;
    logic signed [15:0] bottom;
    logic signed [15:0] right;
    logic signed [15:0] top;
    logic signed [15:0] left;
    logic [7:0]         value;
    logic [9:0]         row;
    logic [9:0]         col;
  } beat_data_t;

  typedef struct packed {
    logic       is_pixel;
    logic       last;
    beat_data_t d;
  } census_item_t;

  typedef struct packed {
    logic [6:0]  pad;
    logic [15:0] dropped;
    logic [10:0] reg_bottom;
    logic [10:0] reg_right;
    logic [14:0] reg_top;
    logic [14:0] reg_left;
    logic [20:0] unexplained;
    logic [20:0] changed;
    logic        done;
    logic [1:0]  code;
  } census_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_idx_i = '0;
  logic [10:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [119:0] m_axis_tdata;

  frame_diff_region_census DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow state of the census.
  logic [7:0]     copy_mem [int];
  bit             copy_ok;
  int             box_l [MaxBoxes];
  int             box_t [MaxBoxes];
  int             box_r [MaxBoxes];
  int             box_b [MaxBoxes];
  int             n_boxes;
  int             n_dropped;
  int             n_changed;
  int             n_unexpl;
  int             bnd_l, bnd_t, bnd_r, bnd_b;
  int             geo_w, geo_h, key_val, vp_en, vp_l, vp_t, vp_r, vp_b;

  census_item_t   pending [$];
  census_result_t awaited [$];
  census_item_t   on_bus;
  int             src_gap, snk_gap, errors;
  bit             quiet;

  // Generator bookkeeping: positions already stored in the frame copy.
  int             filled_c [$];
  int             filled_r [$];
  logic [7:0]     last_val [int];

  function automatic void clear_frame();
    n_boxes = 0;
    n_dropped = 0;
    n_changed = 0;
    n_unexpl = 0;
    bnd_l = NoLow;
    bnd_t = NoLow;
    bnd_r = -1;
    bnd_b = -1;
  endfunction

  function automatic int eff_w();
    return geo_w > MaxWidth ? MaxWidth : geo_w;
  endfunction

  function automatic int eff_h();
    return geo_h > MaxHeight ? MaxHeight : geo_h;
  endfunction

  function automatic bit covered(int x, int y, int v);
    for (int i = 0; i < n_boxes; i++) begin
      if (x >= box_l[i] && x <= box_r[i] && y >= box_t[i] && y <= box_b[i]) return 1'b1;
    end
    return vp_en != 0 && v == key_val && x >= vp_l && x <= vp_r && y >= vp_t && y <= vp_b;
  endfunction

  function automatic void census_step(census_item_t it);
    int l, t, r, b, x, y, idx;
    census_result_t res;
    l = it.d.left;
    t = it.d.top;
    r = it.d.right;
    b = it.d.bottom;
    x = it.d.col;
    y = it.d.row;
    res = '0;
    if (!it.is_pixel) begin
      if (l < 0) l = 0;
      if (t < 0) t = 0;
      if (r > eff_w() - 1) r = eff_w() - 1;
      if (b > eff_h() - 1) b = eff_h() - 1;
      if (l > r || t > b) return;
      if (n_boxes >= MaxBoxes) begin
        if (n_dropped < DropMax) n_dropped++;
        return;
      end
      box_l[n_boxes] = l;
      box_t[n_boxes] = t;
      box_r[n_boxes] = r;
      box_b[n_boxes] = b;
      n_boxes++;
      return;
    end
    res.code = CodeSame;
    if (x < eff_w() && y < eff_h()) begin
      idx = y * MaxWidth + x;
      if (!copy_ok) begin
        copy_mem[idx] = it.d.value;
      end else if (copy_mem[idx] != it.d.value) begin
        copy_mem[idx] = it.d.value;
        if (n_changed < CountMax) n_changed++;
        if (covered(x, y, it.d.value)) begin
          res.code = CodeExpl;
        end else begin
          res.code = CodeUnexp;
          if (n_unexpl < CountMax) n_unexpl++;
          if (x < bnd_l) bnd_l = x;
          if (y < bnd_t) bnd_t = y;
          if (x > bnd_r) bnd_r = x;
          if (y > bnd_b) bnd_b = y;
        end
      end
    end
    if (it.last) begin
      res.done = 1'b1;
      res.changed = 21'(n_changed);
      res.unexplained = 21'(n_unexpl);
      res.reg_left = 15'(bnd_l);
      res.reg_top = 15'(bnd_t);
      res.reg_right = 11'(bnd_r);
      res.reg_bottom = 11'(bnd_b);
      res.dropped = 16'(n_dropped);
      copy_ok = 1'b1;
      clear_frame();
    end
    awaited.push_back(res);
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) census_step(on_bus);
      if (src_gap > 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending.size() > 0) begin
        on_bus = pending.pop_front();
        s_axis_tdata <= on_bus.d;
        s_axis_tuser <= on_bus.is_pixel;
        s_axis_tlast <= on_bus.last;
        s_axis_tvalid <= 1'b1;
        if (!quiet && $urandom_range(0, 9) == 0) src_gap = $urandom_range(1, 15);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    census_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %0h", $time, got);
        errors++;
      end else begin
        want = awaited.pop_front();
        check_field("mask_code", want.code, got.code);
        check_field("frame_done", want.done, got.done);
        check_field("changed_count", want.changed, got.changed);
        check_field("unexplained_count", want.unexplained, got.unexplained);
        check_field("region_left", want.reg_left, got.reg_left);
        check_field("region_top", want.reg_top, got.reg_top);
        check_field("region_right", want.reg_right, got.reg_right);
        check_field("region_bottom", want.reg_bottom, got.reg_bottom);
        check_field("boxes_dropped", want.dropped, got.dropped);
      end
    end
    if (snk_gap > 0) begin
      snk_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!quiet && $urandom_range(0, 7) == 0) snk_gap = $urandom_range(1, 15);
    end
  end

  task automatic write_reg(logic [2:0] idx, int value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value[10:0];
    case (idx)
      RegWidth:  geo_w = value & 'h7FF;
      RegHeight: geo_h = value & 'h7FF;
      RegKey:    key_val = value & 'hFF;
      RegVpEn:   vp_en = value & 1;
      RegVpL:    vp_l = value & 'h3FF;
      RegVpT:    vp_t = value & 'h3FF;
      RegVpR:    vp_r = value & 'h3FF;
      RegVpB:    vp_b = value & 'h3FF;
      default: ;
    endcase
  endtask

  task automatic configure(int w, int h, int key, int en, int l, int t, int r, int b);
    write_reg(RegWidth, w);
    write_reg(RegHeight, h);
    write_reg(RegKey, key);
    write_reg(RegVpEn, en);
    write_reg(RegVpL, l);
    write_reg(RegVpT, t);
    write_reg(RegVpR, r);
    write_reg(RegVpB, b);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending.size() != 0 || s_axis_tvalid || awaited.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic push_box(int l, int t, int r, int b, bit last);
    census_item_t it;
    it.d = beat_data_t'({$urandom, $urandom, $urandom});
    it.is_pixel = 1'b0;
    it.last = last;
    it.d.pad = '0;
    it.d.left = 16'(l);
    it.d.top = 16'(t);
    it.d.right = 16'(r);
    it.d.bottom = 16'(b);
    pending.push_back(it);
  endtask

  task automatic push_pixel(int c, int r, int v, bit last);
    census_item_t it;
    it.d = beat_data_t'({$urandom, $urandom, $urandom});
    it.is_pixel = 1'b1;
    it.last = last;
    it.d.pad = '0;
    it.d.col = 10'(c);
    it.d.row = 10'(r);
    it.d.value = 8'(v);
    last_val[r * MaxWidth + c] = 8'(v);
    pending.push_back(it);
  endtask

  function automatic logic [7:0] prior(int c, int r);
    return last_val.exists(r * MaxWidth + c) ? last_val[r * MaxWidth + c] : 8'h00;
  endfunction

  task automatic random_pixel(bit last);
    int k, c, r, v, sel;
    c = $urandom_range(0, 1023);
    r = $urandom_range(0, 1023);
    if ($urandom_range(0, 9) != 0 || (c < eff_w() && r < eff_h())) begin
      k = $urandom_range(0, filled_c.size() - 1);
      c = filled_c[k];
      r = filled_r[k];
    end
    sel = $urandom_range(0, 9);
    if (sel < 3) v = prior(c, r);
    else if (sel < 5) v = key_val;
    else v = $urandom_range(0, 255);
    push_pixel(c, r, v, last);
  endtask

  task automatic random_box();
    if ($urandom_range(0, 7) == 0) begin
      push_box($urandom_range(0, 65535), $urandom_range(0, 65535),
               $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 9) == 0);
    end else begin
      push_box($urandom_range(0, 24) - 4, $urandom_range(0, 14) - 4,
               $urandom_range(0, 24) - 4, $urandom_range(0, 14) - 4, $urandom_range(0, 9) == 0);
    end
  endtask

  function automatic int pick_size(int usual);
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 1;
      2: return 1024;
      3: return 2047;
      4: return $urandom_range(1, usual);
      default: return usual;
    endcase
  endfunction

  initial begin
    int vl, vt, n_items, n_pix;
    geo_w = 640;
    geo_h = 480;
    key_val = 254;
    vp_en = 0;
    vp_l = 0;
    vp_t = 0;
    vp_r = 0;
    vp_b = 0;
    copy_ok = 1'b0;
    clear_frame();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Fill frame: covers a 16x8 patch and three pixels on the far edges.
    configure(1024, 1024, 254, 0, 0, 0, 0, 0);
    push_box(-32768, -32768, 32767, 32767, 1'b0);
    push_box(2, 2, 5, 5, 1'b1);
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < 16; c++) begin
        push_pixel(c, r, $urandom_range(0, 255), 1'b0);
        filled_c.push_back(c);
        filled_r.push_back(r);
      end
    end
    push_pixel(1023, 7, $urandom_range(0, 255), 1'b0);
    push_pixel(5, 1023, $urandom_range(0, 255), 1'b0);
    push_pixel(1023, 1023, $urandom_range(0, 255), 1'b1);
    filled_c.push_back(1023);
    filled_r.push_back(7);
    filled_c.push_back(5);
    filled_r.push_back(1023);
    filled_c.push_back(1023);
    filled_r.push_back(1023);
    wait_idle();

    configure(16, 8, 254, 1, 2, 1, 5, 3);
    push_box(-32768, -32768, -1, 5, 1'b0);
    push_box(3, 3, 2, 5, 1'b0);
    push_box(10, -5, 12, 2, 1'b0);
    push_pixel(11, 1, prior(11, 1) ^ 8'h80, 1'b0);
    push_pixel(3, 2, 254, 1'b0);
    push_pixel(0, 7, prior(0, 7) ^ 8'hFF, 1'b0);
    push_pixel(15, 0, prior(15, 0), 1'b0);
    push_pixel(1023, 1023, 0, 1'b0);
    push_pixel(7, 7, prior(7, 7) ^ 8'h01, 1'b1);
    push_box(-32768, -32768, 32767, 32767, 1'b0);
    for (int i = 0; i < 69; i++) push_box(0, 0, 0, 0, 1'b0);
    push_pixel(5, 5, prior(5, 5) ^ 8'h03, 1'b1);
    push_pixel(6, 6, prior(6, 6) ^ 8'h10, 1'b1);
    wait_idle();

    for (int ph = 0; ph < 9; ph++) begin
      vl = $urandom_range(0, 10);
      vt = $urandom_range(0, 6);
      if (ph == 8) quiet = 1'b1;
      if (ph == 1) begin
        configure(2047, 2047, 0, 1, 0, 0, 1023, 1023);
      end else if (ph == 2) begin
        configure(0, 0, 255, 0, 1023, 1023, 1023, 1023);
      end else begin
        configure(pick_size(16), pick_size(8), $urandom_range(0, 255), $urandom_range(0, 1),
                  vl, vt, $urandom_range(vl, 20), $urandom_range(vt, 10));
      end
      n_items = 0;
      while (n_items < 20) begin
        n_pix = $urandom_range(1, 20);
        for (int i = $urandom_range(0, 4); i > 0; i--) begin
          random_box();
          n_items++;
        end
        for (int i = 0; i < n_pix; i++) begin
          if ($urandom_range(0, 7) == 0) begin
            random_box();
            n_items++;
          end
          random_pixel(i == n_pix - 1);
          n_items++;
        end
      end
      wait_idle();
    end

    if (errors == 0 && awaited.size() == 0) begin
      $display("[frame_diff_region_census] OK");
    end else begin
      $display("[frame_diff_region_census] ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[frame_diff_region_census] ERROR");
    $finish;
  end
endmodule
`default_nettype wire

FILE: frame_diff_region_census.f
hw/rtl/fdrc_pkg.sv
hw/rtl/fdrc_ram.sv
hw/rtl/fdrc_ctrl.sv
hw/rtl/fdrc_dp.sv
hw/rtl/frame_diff_region_census.sv
tb/tb_top.sv
